// ===== hw/rtl/sorted_timer_queue_unit_defines.svh =====
`ifndef SORTED_TIMER_QUEUE_UNIT_DEFINES_SVH
`define SORTED_TIMER_QUEUE_UNIT_DEFINES_SVH

// rule that holds in the same cycle as its trigger
`define STQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stq: same-cycle rule broken");

// rule that holds in the cycle after its trigger
`define STQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stq: next-cycle rule broken");

`endif

// ===== hw/rtl/stq_pkg.sv =====
`timescale 1ns / 1ps

package stq_pkg;

    typedef enum logic [1:0] {
        OP_SET,
        OP_DELETE,
        OP_DELETE_ALL,
        OP_CHECK
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_WR,
        ST_DEL_CMP,
        ST_DEL_MOVE,
        ST_DEL_END,
        ST_CHK_CMP,
        ST_CHK_END
    } t_state;

    localparam logic [2:0] KIND_SET_OK      = 3'd0;
    localparam logic [2:0] KIND_SET_REFUSED = 3'd1;
    localparam logic [2:0] KIND_EXPIRED     = 3'd2;
    localparam logic [2:0] KIND_NEXT        = 3'd3;
    localparam logic [2:0] KIND_NONE        = 3'd4;
    localparam logic [2:0] KIND_DEL_DONE    = 3'd5;

endpackage

// ===== hw/rtl/sorted_timer_queue_unit.sv =====
`timescale 1ns / 1ps

// Sorted one-shot timer queue. Timers sit in a ring memory in ascending expiry order,
// equal expiries first in, first out; one subtractor does every expiry comparison and a
// small sequencer walks the ring one entry a cycle through the memory's single read port.
// An item is taken when start is high and busy is low; results come out on o_strobe, one
// per cycle, and cannot be held off, so they must be captured when the strobe is high.
// A refused set, delete-all, a delete of a free handle or a check of an empty queue
// walk no entries; an accepted set is compared with every queued timer that expires
// later and, if there is one, the latest that does not; a delete walks every queued
// timer; a check of a non-empty queue gives one result per expired timer, ending with
// the next-timeout or none-pending result.
module sorted_timer_queue_unit #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_now_seconds,
    input  logic [15:0] i_duration,
    input  logic [3:0]  i_handle,
    input  logic [15:0] i_user_tag,
    output logic        o_strobe,
    output logic [2:0]  o_kind,
    output logic [3:0]  o_slot,
    output logic [15:0] o_tag_out,
    output logic [15:0] o_remaining,
    output logic        o_last
);
    import stq_pkg::*;

    localparam int SW = $clog2(TIMER_SLOTS);
    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam int IW = (SW > 4) ? SW : 4;
    localparam logic [SW-1:0] LAST_IX = SW'(TIMER_SLOTS - 1);

    function automatic logic [SW-1:0] f_inc(input logic [SW-1:0] p);
        return (p == LAST_IX) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [SW-1:0] f_dec(input logic [SW-1:0] p);
        return (p == '0) ? LAST_IX : p - 1'b1;
    endfunction

    // timer ring
    logic [31:0]   r_mem_exp  [TIMER_SLOTS];
    logic [SW-1:0] r_mem_slot [TIMER_SLOTS];
    logic [15:0]   r_mem_tag  [TIMER_SLOTS];

    t_state           r_state, n_state;
    logic [SW-1:0]    r_head, n_head;
    logic [SW-1:0]    r_tail, n_tail;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_left, n_left;
    logic [SW-1:0]    r_ptr, n_ptr;
    logic [31:0]      r_key, n_key;
    logic [SW-1:0]    r_new_slot, n_new_slot;
    logic [15:0]      r_new_tag, n_new_tag;
    logic [SW-1:0]    r_hidx, n_hidx;
    logic [TIMER_SLOTS-1:0] r_busy_map, n_busy_map;

    logic [31:0]      r_rd_exp;
    logic [SW-1:0]    r_rd_slot;
    logic [15:0]      r_rd_tag;

    logic             r_strobe, n_strobe;
    logic [2:0]       r_kind, n_kind;
    logic [3:0]       r_oslot, n_oslot;
    logic [15:0]      r_otag, n_otag;
    logic [15:0]      r_orem, n_orem;
    logic             r_olast, n_olast;

    logic             mem_we;
    logic [SW-1:0]    mem_waddr;
    logic [31:0]      mem_wexp;
    logic [SW-1:0]    mem_wslot;
    logic [15:0]      mem_wtag;
    logic             rd_en;
    logic [SW-1:0]    rd_addr;

    logic             accept;
    t_op              op;
    logic             free_found;
    logic [SW-1:0]    free_ix;
    logic [32:0]      set_sum;
    logic [31:0]      set_exp;
    logic             set_ok;
    logic [IW-1:0]    h_ext;
    logic             h_in_range;
    logic [SW-1:0]    h_ix;
    logic             del_ok;
    logic [32:0]      sub_diff;
    logic             rd_after_key;
    logic [15:0]      rem_sat;
    logic             del_match;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign op       = t_op'(i_operation);

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_ix    = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!r_busy_map[i]) begin
                free_found = 1'b1;
                free_ix    = SW'(i);
            end
        end
    end

    assign set_sum    = {1'b0, i_now_seconds} + 33'(i_duration);
    assign set_exp    = set_sum[32] ? 32'hFFFF_FFFF : set_sum[31:0];
    assign set_ok     = (i_duration != 16'd0) && free_found;

    assign h_ext      = IW'(i_handle);
    assign h_in_range = {1'b0, h_ext} < (IW + 1)'(TIMER_SLOTS);
    assign h_ix       = h_ext[SW-1:0];
    assign del_ok     = h_in_range && r_busy_map[h_ix];

    // shared compare unit
    assign sub_diff     = {1'b0, r_rd_exp} - {1'b0, r_key};
    assign rd_after_key = !sub_diff[32] && (sub_diff[31:0] != 32'd0);
    assign rem_sat      = (sub_diff[31:16] != 16'd0) ? 16'hFFFF : sub_diff[15:0];
    assign del_match    = (r_rd_slot == r_hidx);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_SET: begin
                            if (set_ok) begin
                                n_state = (r_count != '0) ? ST_INS_CMP : ST_INS_WR;
                            end
                        end
                        OP_DELETE: begin
                            if (del_ok) begin
                                n_state = ST_DEL_CMP;
                            end
                        end
                        OP_CHECK: begin
                            if (r_count != '0) begin
                                n_state = ST_CHK_CMP;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_INS_CMP: begin
                if (!(rd_after_key && (r_left > CW'(1)))) begin
                    n_state = ST_INS_WR;
                end
            end
            ST_INS_WR: n_state = ST_IDLE;
            ST_DEL_CMP: begin
                if (r_left <= CW'(1)) begin
                    n_state = ST_DEL_END;
                end else if (del_match) begin
                    n_state = ST_DEL_MOVE;
                end
            end
            ST_DEL_MOVE: begin
                if (r_left <= CW'(1)) begin
                    n_state = ST_DEL_END;
                end
            end
            ST_DEL_END: n_state = ST_IDLE;
            ST_CHK_CMP: begin
                if (rd_after_key) begin
                    n_state = ST_IDLE;
                end else if (r_count <= CW'(1)) begin
                    n_state = ST_CHK_END;
                end
            end
            ST_CHK_END: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_left     = r_left;
        n_ptr      = r_ptr;
        n_key      = r_key;
        n_new_slot = r_new_slot;
        n_new_tag  = r_new_tag;
        n_hidx     = r_hidx;
        n_busy_map = r_busy_map;
        mem_we     = 1'b0;
        mem_waddr  = r_ptr;
        mem_wexp   = r_rd_exp;
        mem_wslot  = r_rd_slot;
        mem_wtag   = r_rd_tag;
        rd_en      = 1'b0;
        rd_addr    = r_ptr;
        n_strobe   = 1'b0;
        n_kind     = KIND_SET_OK;
        n_oslot    = 4'd0;
        n_otag     = 16'd0;
        n_orem     = 16'd0;
        n_olast    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_SET: begin
                            if (set_ok) begin
                                n_key      = set_exp;
                                n_new_slot = free_ix;
                                n_new_tag  = i_user_tag;
                                n_ptr      = f_dec(r_tail);
                                n_left     = r_count;
                                rd_en      = (r_count != '0);
                                rd_addr    = f_dec(r_tail);
                            end else begin
                                n_strobe = 1'b1;
                                n_kind   = KIND_SET_REFUSED;
                                n_olast  = 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            if (del_ok) begin
                                n_hidx  = h_ix;
                                n_ptr   = r_head;
                                n_left  = r_count;
                                rd_en   = 1'b1;
                                rd_addr = r_head;
                            end else begin
                                n_strobe = 1'b1;
                                n_kind   = KIND_DEL_DONE;
                                n_olast  = 1'b1;
                            end
                        end
                        OP_DELETE_ALL: begin
                            n_head     = '0;
                            n_tail     = '0;
                            n_count    = '0;
                            n_busy_map = '0;
                            n_strobe   = 1'b1;
                            n_kind     = KIND_DEL_DONE;
                            n_olast    = 1'b1;
                        end
                        OP_CHECK: begin
                            n_key = i_now_seconds;
                            if (r_count != '0) begin
                                rd_en   = 1'b1;
                                rd_addr = r_head;
                            end else begin
                                n_strobe = 1'b1;
                                n_kind   = KIND_NONE;
                                n_olast  = 1'b1;
                            end
                        end
                        default: n_strobe = 1'b0;
                    endcase
                end
            end
            ST_INS_CMP: begin
                // later entry moves one place towards the tail
                if (rd_after_key) begin
                    mem_we    = 1'b1;
                    mem_waddr = f_inc(r_ptr);
                    n_ptr     = f_dec(r_ptr);
                    n_left    = r_left - 1'b1;
                    rd_en     = (r_left > CW'(1));
                    rd_addr   = f_dec(r_ptr);
                end
            end
            ST_INS_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = f_inc(r_ptr);
                mem_wexp   = r_key;
                mem_wslot  = r_new_slot;
                mem_wtag   = r_new_tag;
                n_count    = r_count + 1'b1;
                n_tail     = f_inc(r_tail);
                n_busy_map[r_new_slot] = 1'b1;
                n_strobe   = 1'b1;
                n_kind     = KIND_SET_OK;
                n_oslot    = 4'(r_new_slot);
                n_olast    = 1'b1;
            end
            ST_DEL_CMP: begin
                n_left  = r_left - 1'b1;
                rd_en   = (r_left > CW'(1));
                if (del_match) begin
                    rd_addr = f_inc(r_ptr);
                end else begin
                    n_ptr   = f_inc(r_ptr);
                    rd_addr = f_inc(r_ptr);
                end
            end
            ST_DEL_MOVE: begin
                // close the gap left by the deleted entry
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                n_ptr     = f_inc(r_ptr);
                n_left    = r_left - 1'b1;
                rd_en     = (r_left > CW'(1));
                rd_addr   = f_inc(f_inc(r_ptr));
            end
            ST_DEL_END: begin
                n_count  = r_count - 1'b1;
                n_tail   = f_dec(r_tail);
                n_busy_map[r_hidx] = 1'b0;
                n_strobe = 1'b1;
                n_kind   = KIND_DEL_DONE;
                n_olast  = 1'b1;
            end
            ST_CHK_CMP: begin
                n_strobe = 1'b1;
                if (!rd_after_key) begin
                    n_kind     = KIND_EXPIRED;
                    n_oslot    = 4'(r_rd_slot);
                    n_otag     = r_rd_tag;
                    n_busy_map[r_rd_slot] = 1'b0;
                    n_head     = f_inc(r_head);
                    n_count    = r_count - 1'b1;
                    rd_en      = (r_count > CW'(1));
                    rd_addr    = f_inc(r_head);
                end else begin
                    n_kind  = KIND_NEXT;
                    n_orem  = rem_sat;
                    n_olast = 1'b1;
                end
            end
            ST_CHK_END: begin
                n_strobe = 1'b1;
                n_kind   = KIND_NONE;
                n_olast  = 1'b1;
            end
            default: n_strobe = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_exp[mem_waddr]  <= mem_wexp;
            r_mem_slot[mem_waddr] <= mem_wslot;
            r_mem_tag[mem_waddr]  <= mem_wtag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_exp  <= r_mem_exp[rd_addr];
            r_rd_slot <= r_mem_slot[rd_addr];
            r_rd_tag  <= r_mem_tag[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_busy_map <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_busy_map <= n_busy_map;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left     <= n_left;
        r_ptr      <= n_ptr;
        r_key      <= n_key;
        r_new_slot <= n_new_slot;
        r_new_tag  <= n_new_tag;
        r_hidx     <= n_hidx;
        r_kind     <= n_kind;
        r_oslot    <= n_oslot;
        r_otag     <= n_otag;
        r_orem     <= n_orem;
        r_olast    <= n_olast;
    end

    assign o_strobe    = r_strobe;
    assign o_kind      = r_kind;
    assign o_slot      = r_oslot;
    assign o_tag_out   = r_otag;
    assign o_remaining = r_orem;
    assign o_last      = r_olast;

endmodule

// ===== hw/rtl/stq_checker.sv =====
`timescale 1ns / 1ps
`include "sorted_timer_queue_unit_defines.svh"

module stq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_operation,
    input logic        o_strobe,
    input logic [2:0]  o_kind,
    input logic [15:0] o_remaining,
    input logic        o_last
);
    import stq_pkg::*;

    // only expired results leave more to follow
    `STQ_ASSERT_SAME(a_nonfinal_is_expired, o_strobe && !o_last, o_kind == KIND_EXPIRED)
    // an expired result is always followed at once by another result
    `STQ_ASSERT_NEXT(a_expired_continues, o_strobe && o_kind == KIND_EXPIRED, o_strobe)
    `STQ_ASSERT_SAME(a_remaining_zero, o_strobe && o_kind != KIND_NEXT, o_remaining == 16'd0)
    `STQ_ASSERT_NEXT(a_delete_all_quick, start && !busy && i_operation == OP_DELETE_ALL, o_strobe && o_last && o_kind == KIND_DEL_DONE)
    // the block is free again once the final result of an item shows
    `STQ_ASSERT_SAME(a_free_after_last, o_strobe && o_last, !busy)

endmodule

bind sorted_timer_queue_unit stq_checker u_stq_checker (.*);
